// ----- rtl/core/tcs_pkg.sv -----
`default_nettype none

package tcs_pkg;

   localparam int LINE_WIDTH  = 24;
   localparam int OUT_LINE_W  = 24;
   localparam int MAX_RES     = 4;
   localparam int FIFO_DEPTH  = 8;
   localparam int PTR_W       = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int RES_CNT_W   = $clog2(MAX_RES + 1);

   localparam logic [15:0] EXPR_LIMIT_RESET = 16'd1024;
   localparam logic [15:0] LIMIT_MARGIN     = 16'd8;

   localparam logic [7:0] CHAR_TAB    = 8'd9;
   localparam logic [7:0] CHAR_LF     = 8'd10;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_DQUOTE = 8'd34;
   localparam logic [7:0] CHAR_DOLLAR = 8'd36;
   localparam logic [7:0] CHAR_SQUOTE = 8'd39;
   localparam logic [7:0] CHAR_STAR   = 8'd42;
   localparam logic [7:0] CHAR_SLASH  = 8'd47;
   localparam logic [7:0] CHAR_SEMI   = 8'd59;
   localparam logic [7:0] CHAR_LT     = 8'd60;
   localparam logic [7:0] CHAR_GT     = 8'd62;

   typedef enum logic [2:0] {
      MODE_TEXT   = 3'd0,
      MODE_CODE   = 3'd1,
      MODE_SQUOTE = 3'd2,
      MODE_DQUOTE = 3'd3,
      MODE_BLOCK  = 3'd4,
      MODE_LINE   = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      SW_NONE    = 2'd0,
      SW_DROP    = 2'd1,
      SW_TEXT_LF = 2'd2
   } swallow_type;

   typedef struct packed {
      mode_type                mode;
      logic [7:0]              held_byte;
      logic                    held_valid;
      swallow_type             swallow;
      logic [LINE_WIDTH-1:0]   line_count;
      logic [15:0]             kept_length;
      logic                    after_semi;
      logic                    last_space;
      logic [LINE_WIDTH-1:0]   start_line;
   } state_type;

   typedef struct packed {
      logic [7:0]              char_value;
      logic                    char_valid;
      logic                    expr_end;
      logic [2:0]              expr_kind;
      logic [15:0]             expr_length;
      logic [OUT_LINE_W-1:0]   expr_line;
      logic                    error;
   } result_type;

   typedef struct packed {
      state_type               st;
      result_type              res0;
      result_type              res1;
      logic [1:0]              count;
      logic                    ended;
   } step_type;

   localparam state_type STATE_RESET = '{
      mode:        MODE_TEXT,
      held_byte:   8'd0,
      held_valid:  1'b0,
      swallow:     SW_NONE,
      line_count:  '0,
      kept_length: 16'd0,
      after_semi:  1'b0,
      last_space:  1'b0,
      start_line:  LINE_WIDTH'(1)
   };

   function automatic logic [OUT_LINE_W-1:0] line_field(logic [LINE_WIDTH-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      if (w > 33'((1 << OUT_LINE_W) - 1)) begin
         return '1;
      end
      return w[OUT_LINE_W-1:0];
   endfunction

   function automatic result_type mk_char(logic [7:0] c);
      result_type r;
      r            = '0;
      r.char_value = c;
      r.char_valid = 1'b1;
      return r;
   endfunction

   function automatic result_type mk_end(mode_type kind, logic [15:0] len,
                                          logic [LINE_WIDTH-1:0] line, logic err);
      result_type r;
      r             = '0;
      r.expr_end    = 1'b1;
      r.expr_kind   = kind;
      r.expr_length = len;
      r.expr_line   = line_field(line);
      r.error       = err;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tcs_handle.sv -----
`default_nettype none

module tcs_handle (
   input  tcs_pkg::state_type st_i,
   input  logic [7:0]         ch_i,
   input  logic [7:0]         nx_i,
   input  logic [15:0]        thresh_i,
   output tcs_pkg::step_type  step_o
);
   import tcs_pkg::*;

   state_type  s;
   result_type r0;
   result_type r1;
   result_type rx;
   logic [1:0] cnt;
   logic       ended;
   logic       eol;

   function automatic logic [LINE_WIDTH-1:0] line_plus(logic [LINE_WIDTH-1:0] v);
      return (&v) ? v : LINE_WIDTH'(v + LINE_WIDTH'(1));
   endfunction

   function automatic state_type new_expr(state_type x);
      state_type y;
      y             = x;
      y.kept_length = 16'd0;
      y.after_semi  = 1'b0;
      y.last_space  = 1'b0;
      y.start_line  = line_plus(x.line_count);
      return y;
   endfunction

   function automatic state_type count_line(state_type x);
      state_type y;
      y            = x;
      y.line_count = line_plus(x.line_count);
      return y;
   endfunction

   function automatic state_type keep_byte(state_type x, logic [7:0] c);
      state_type y;
      y             = x;
      y.kept_length = 16'(x.kept_length + 16'd1);
      y.last_space  = (c == CHAR_SPACE);
      return y;
   endfunction

   function automatic state_type overflow_state(state_type x);
      state_type y;
      y         = x;
      y.mode    = MODE_TEXT;
      y.swallow = SW_NONE;
      return new_expr(y);
   endfunction

   always_comb begin
      s     = st_i;
      r0    = '0;
      r1    = '0;
      rx    = '0;
      cnt   = 2'd0;
      ended = 1'b0;
      eol   = (ch_i == CHAR_LF) || ((ch_i == CHAR_CR) && (nx_i == CHAR_LF));
      if (s.swallow == SW_DROP) begin
         s.swallow = SW_NONE;
      end else if (s.swallow == SW_TEXT_LF) begin
         s.swallow = SW_NONE;
         r0  = mk_char(ch_i);
         cnt = 2'd1;
         s   = keep_byte(s, ch_i);
         if (s.kept_length >= thresh_i) begin
            r1    = mk_end(MODE_TEXT, s.kept_length, s.start_line, 1'b0);
            cnt   = 2'd2;
            s     = new_expr(s);
            ended = 1'b1;
         end
      end else begin
         unique case (s.mode)
            MODE_SQUOTE, MODE_DQUOTE: begin
               if (s.kept_length >= thresh_i) begin
                  r0    = mk_end(s.mode, s.kept_length, s.start_line, 1'b1);
                  cnt   = 2'd1;
                  s     = overflow_state(s);
                  ended = 1'b1;
               end else begin
                  if (((s.mode == MODE_SQUOTE) && (ch_i == CHAR_SQUOTE)) ||
                      ((s.mode == MODE_DQUOTE) && (ch_i == CHAR_DQUOTE))) begin
                     s.mode = MODE_CODE;
                  end
                  r0  = mk_char(ch_i);
                  cnt = 2'd1;
                  s   = keep_byte(s, ch_i);
               end
            end
            MODE_BLOCK: begin
               if (ch_i == CHAR_LF) begin
                  s = count_line(s);
               end
               if ((ch_i == CHAR_STAR) && (nx_i == CHAR_SLASH)) begin
                  s.swallow = SW_DROP;
                  s.mode    = MODE_CODE;
               end
            end
            MODE_LINE: begin
               if (eol) begin
                  if (ch_i == CHAR_CR) begin
                     s.swallow = SW_DROP;
                  end
                  s      = count_line(s);
                  s.mode = MODE_CODE;
                  if (s.after_semi) begin
                     s.after_semi = 1'b0;
                  end else if (s.kept_length != 16'd0) begin
                     r0    = mk_end(MODE_CODE, s.kept_length, s.start_line, 1'b0);
                     cnt   = 2'd1;
                     s     = new_expr(s);
                     ended = 1'b1;
                  end
               end
            end
            MODE_CODE: begin
               if ((ch_i == CHAR_DOLLAR) && (nx_i == CHAR_GT)) begin
                  s.swallow = SW_DROP;
                  r0        = mk_end(MODE_CODE, s.kept_length, s.start_line, 1'b0);
                  cnt       = 2'd1;
                  s         = new_expr(s);
                  ended     = 1'b1;
                  s.mode    = MODE_TEXT;
               end else if ((ch_i == CHAR_SLASH) && (nx_i == CHAR_STAR)) begin
                  s.mode = MODE_BLOCK;
               end else if ((ch_i == CHAR_SLASH) && (nx_i == CHAR_SLASH)) begin
                  s.mode = MODE_LINE;
               end else if (eol) begin
                  if (ch_i == CHAR_CR) begin
                     s.swallow = SW_DROP;
                  end
                  s = count_line(s);
                  if (s.after_semi) begin
                     s.after_semi = 1'b0;
                  end else if (s.kept_length != 16'd0) begin
                     r0    = mk_end(MODE_CODE, s.kept_length, s.start_line, 1'b0);
                     cnt   = 2'd1;
                     s     = new_expr(s);
                     ended = 1'b1;
                  end
               end else if (ch_i == CHAR_SEMI) begin
                  s.after_semi = 1'b1;
               end else if ((ch_i == CHAR_SPACE) || (ch_i == CHAR_TAB)) begin
                  if ((s.kept_length != 16'd0) && !s.last_space) begin
                     if (s.kept_length >= thresh_i) begin
                        r0    = mk_end(s.mode, s.kept_length, s.start_line, 1'b1);
                        cnt   = 2'd1;
                        s     = overflow_state(s);
                        ended = 1'b1;
                     end else begin
                        r0  = mk_char(CHAR_SPACE);
                        cnt = 2'd1;
                        s   = keep_byte(s, CHAR_SPACE);
                     end
                  end
               end else begin
                  if (s.after_semi && (s.kept_length != 16'd0)) begin
                     r0    = mk_end(MODE_CODE, s.kept_length, s.start_line, 1'b0);
                     cnt   = 2'd1;
                     s     = new_expr(s);
                     ended = 1'b1;
                  end
                  if (s.kept_length == 16'd0) begin
                     s.start_line = line_plus(s.line_count);
                  end
                  if (s.kept_length >= thresh_i) begin
                     rx    = mk_end(s.mode, s.kept_length, s.start_line, 1'b1);
                     s     = overflow_state(s);
                     ended = 1'b1;
                  end else begin
                     rx = mk_char(ch_i);
                     s  = keep_byte(s, ch_i);
                     if (ch_i == CHAR_SQUOTE) begin
                        s.mode = MODE_SQUOTE;
                     end else if (ch_i == CHAR_DQUOTE) begin
                        s.mode = MODE_DQUOTE;
                     end
                  end
                  if (cnt == 2'd0) begin
                     r0 = rx;
                  end else begin
                     r1 = rx;
                  end
                  cnt = 2'(cnt + 2'd1);
               end
            end
            default: begin
               s.mode = MODE_TEXT;
               if (eol && (ch_i == CHAR_CR)) begin
                  s         = count_line(s);
                  r0        = mk_char(ch_i);
                  cnt       = 2'd1;
                  s         = keep_byte(s, ch_i);
                  s.swallow = SW_TEXT_LF;
               end else begin
                  if (eol) begin
                     s = count_line(s);
                  end
                  if ((ch_i == CHAR_LT) && (nx_i == CHAR_DOLLAR)) begin
                     s.swallow = SW_DROP;
                     s.mode    = MODE_CODE;
                     if (s.kept_length != 16'd0) begin
                        r0    = mk_end(MODE_TEXT, s.kept_length, s.start_line, 1'b0);
                        cnt   = 2'd1;
                        s     = new_expr(s);
                        ended = 1'b1;
                     end
                  end else begin
                     r0  = mk_char(ch_i);
                     cnt = 2'd1;
                     s   = keep_byte(s, ch_i);
                     if (s.kept_length >= thresh_i) begin
                        r1    = mk_end(MODE_TEXT, s.kept_length, s.start_line, 1'b0);
                        cnt   = 2'd2;
                        s     = new_expr(s);
                        ended = 1'b1;
                     end
                  end
               end
            end
         endcase
      end
   end

   assign step_o.st    = s;
   assign step_o.res0  = r0;
   assign step_o.res1  = r1;
   assign step_o.count = cnt;
   assign step_o.ended = ended;

endmodule

`default_nettype wire

// ----- rtl/core/template_text_code_splitter.sv -----
`default_nettype none
// A request beat is registered and judged once the result queue has room; the result beats
// it releases are written into that queue and offered from its head. A byte is judged only
// when the byte after it arrives, so its own results come with the next beat, or with itself
// when last. One request beat per cycle while each byte yields at most one result and the
// result port is not stalled; the single result port drains an eight-entry result queue,
// and input stalls while the queue holds more than four beats.
// Reset is synchronous: text mode, no lookahead, line one, expression limit 1024.

module template_text_code_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_char_value,
   output logic        rsp_char_valid,
   output logic        rsp_expr_end,
   output logic [2:0]  rsp_expr_kind,
   output logic [15:0] rsp_expr_length,
   output logic [23:0] rsp_expr_line,
   output logic        rsp_error,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import tcs_pkg::*;

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic [15:0]          thr_ff;
   logic [15:0]          thr_in;
   state_type            st_ff;
   state_type            st_in;
   state_type            st_a;
   step_type             h1_out;
   step_type             h2_out;
   logic [1:0]           cnt_a;
   logic                 ended_a;
   logic                 fin_needed;
   result_type           res_list [MAX_RES+1];
   logic [2:0]           idx;
   logic [RES_CNT_W-1:0] npush;
   result_type           fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [PTR_W-1:0]     wr_slot [MAX_RES];
   logic                 process;
   logic                 pop;
   result_type           head;

   assign process   = in_valid_ff && (cnt_ff <= CNT_W'(FIFO_DEPTH - MAX_RES));
   assign req_ready = !in_valid_ff || process;
   assign thr_in    = (csr_wr_data < LIMIT_MARGIN) ? 16'd0 : 16'(csr_wr_data - LIMIT_MARGIN);

   tcs_handle u_handle_held (
      .st_i     (st_ff),
      .ch_i     (st_ff.held_byte),
      .nx_i     (in_byte_ff),
      .thresh_i (thr_ff),
      .step_o   (h1_out)
   );

   always_comb begin
      if (st_ff.held_valid) begin
         st_a    = h1_out.st;
         cnt_a   = h1_out.count;
         ended_a = h1_out.ended;
      end else begin
         st_a    = st_ff;
         cnt_a   = 2'd0;
         ended_a = 1'b0;
      end
      st_a.held_byte  = in_byte_ff;
      st_a.held_valid = 1'b1;
   end

   tcs_handle u_handle_last (
      .st_i     (st_a),
      .ch_i     (in_byte_ff),
      .nx_i     (8'd0),
      .thresh_i (thr_ff),
      .step_o   (h2_out)
   );

   always_comb begin
      fin_needed = (h2_out.st.kept_length != 16'd0) || !(ended_a || h2_out.ended);
      for (int k = 0; k <= MAX_RES; k++) begin
         res_list[k] = '0;
      end
      idx = 3'd0;
      if (cnt_a != 2'd0) begin
         res_list[idx] = h1_out.res0;
         idx = 3'(idx + 3'd1);
      end
      if (cnt_a == 2'd2) begin
         res_list[idx] = h1_out.res1;
         idx = 3'(idx + 3'd1);
      end
      if (in_last_ff) begin
         if (h2_out.count != 2'd0) begin
            res_list[idx] = h2_out.res0;
            idx = 3'(idx + 3'd1);
         end
         if (h2_out.count == 2'd2) begin
            res_list[idx] = h2_out.res1;
            idx = 3'(idx + 3'd1);
         end
         if (fin_needed) begin
            res_list[idx] = mk_end(h2_out.st.mode, h2_out.st.kept_length,
                                   h2_out.st.start_line, 1'b0);
            idx = 3'(idx + 3'd1);
         end
         st_in = STATE_RESET;
      end else begin
         st_in = st_a;
      end
      npush = (idx > 3'(MAX_RES)) ? RES_CNT_W'(MAX_RES) : RES_CNT_W'(idx);
   end

   always_comb begin
      for (int k = 0; k < MAX_RES; k++) begin
         wr_slot[k] = PTR_W'(wr_ptr_ff + PTR_W'(k));
      end
   end

   assign head   = fifo_ff[rd_ptr_ff];
   assign pop    = rsp_valid && rsp_ready;
   assign cnt_in = CNT_W'(cnt_ff - CNT_W'(pop) + (process ? CNT_W'(npush) : CNT_W'(0)));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff       <= STATE_RESET;
         thr_ff      <= 16'(EXPR_LIMIT_RESET - LIMIT_MARGIN);
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (process) begin
            in_valid_ff <= 1'b0;
         end
         if (process) begin
            st_ff     <= st_in;
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + PTR_W'(npush));
         end
         if (csr_wr_en) begin
            thr_ff <= thr_in;
         end
         if (pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + PTR_W'(1));
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_is_last;
      end
      for (int k = 0; k < MAX_RES; k++) begin
         if (process && (RES_CNT_W'(k) < npush)) begin
            fifo_ff[wr_slot[k]] <= res_list[k];
         end
      end
   end

   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_char_value  = head.char_value;
   assign rsp_char_valid  = head.char_valid;
   assign rsp_expr_end    = head.expr_end;
   assign rsp_expr_kind   = head.expr_kind;
   assign rsp_expr_length = head.expr_length;
   assign rsp_expr_line   = head.expr_line;
   assign rsp_error       = head.error;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FIFO_DEPTH))
      else $error("Result queue holds more beats than it has entries.");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      process && in_last_ff |=> !st_ff.held_valid && (st_ff.mode == MODE_TEXT) &&
                                (st_ff.kept_length == 16'd0))
      else $error("Final byte did not return the splitter to its reset state.");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      process && in_last_ff |-> npush != '0)
      else $error("Final byte produced no end mark.");

   a_held_byte: assert property (@(posedge clock) disable iff (reset)
      process && !in_last_ff |=> st_ff.held_valid && (st_ff.held_byte == $past(in_byte_ff)))
      else $error("Lookahead byte was not captured.");

endmodule

`default_nettype wire

// ----- sim/template_text_code_splitter_tb.sv -----
`timescale 1ns / 100ps

module template_text_code_splitter_tb;
   import tcs_pkg::*;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } src_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_value = 8'd0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_char_value;
   logic        rsp_char_valid;
   logic        rsp_expr_end;
   logic [2:0]  rsp_expr_kind;
   logic [15:0] rsp_expr_length;
   logic [23:0] rsp_expr_line;
   logic        rsp_error;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   src_byte_type source_bytes[$];
   result_type  split_results[$];
   logic [7:0]  file_buf[$];
   int          unsent_bytes = 0;
   int          failures = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          send_gap = 0;
   int          hold_cycles = 0;
   bit          want_squeeze = 1'b0;
   bit          squeeze_done = 1'b0;

   // Mirror of the splitter state.
   logic [15:0]           limit_reg;
   mode_type              sp_mode;
   logic [7:0]            sp_held;
   logic                  sp_held_ok;
   swallow_type           sp_swallow;
   logic [LINE_WIDTH-1:0] sp_lines;
   logic [15:0]           sp_len;
   logic                  sp_semi;
   logic                  sp_space;
   logic [LINE_WIDTH-1:0] sp_start;
   logic                  sp_ended;
   int                    sp_count;

   template_text_code_splitter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_value  (req_byte_value),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_value  (rsp_char_value),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_expr_end    (rsp_expr_end),
      .rsp_expr_kind   (rsp_expr_kind),
      .rsp_expr_length (rsp_expr_length),
      .rsp_expr_line   (rsp_expr_line),
      .rsp_error       (rsp_error),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [LINE_WIDTH-1:0] next_line(input logic [LINE_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [15:0] split_point(input logic [15:0] lim);
      return (lim < 16'd8) ? 16'd0 : lim - 16'd8;
   endfunction

   task automatic emit(input logic [7:0] c, input logic valid, input logic fin,
                       input logic [2:0] kind, input logic [15:0] len,
                       input logic [LINE_WIDTH-1:0] line, input logic err);
      result_type r;
      if (sp_count >= MAX_RES) return;
      r.char_value  = c;
      r.char_valid  = valid;
      r.expr_end    = fin;
      r.expr_kind   = kind;
      r.expr_length = len;
      r.expr_line   = line;
      r.error       = err;
      split_results.push_back(r);
      sp_count++;
   endtask

   task automatic open_expr();
      sp_len   = 16'd0;
      sp_semi  = 1'b0;
      sp_space = 1'b0;
      sp_start = next_line(sp_lines);
   endtask

   task automatic close_expr(input logic [2:0] kind);
      emit(8'd0, 1'b0, 1'b1, kind, sp_len, sp_start, 1'b0);
      open_expr();
      sp_ended = 1'b1;
   endtask

   task automatic overflow_expr();
      emit(8'd0, 1'b0, 1'b1, sp_mode, sp_len, sp_start, 1'b1);
      sp_mode    = MODE_TEXT;
      sp_swallow = SW_NONE;
      open_expr();
      sp_ended = 1'b1;
   endtask

   task automatic keep_byte(input logic [7:0] c);
      emit(c, 1'b1, 1'b0, 3'd0, 16'd0, '0, 1'b0);
      sp_len   = sp_len + 16'd1;
      sp_space = (c == CHAR_SPACE);
   endtask

   task automatic clear_split();
      sp_mode    = MODE_TEXT;
      sp_held    = 8'd0;
      sp_held_ok = 1'b0;
      sp_swallow = SW_NONE;
      sp_lines   = '0;
      sp_len     = 16'd0;
      sp_semi    = 1'b0;
      sp_space   = 1'b0;
      sp_start   = LINE_WIDTH'(1);
   endtask

   // Judges one byte with the byte after it as lookahead.
   task automatic judge_byte(input logic [7:0] ch, input logic [7:0] nx);
      logic eol;
      eol = (ch == CHAR_LF) || (ch == CHAR_CR && nx == CHAR_LF);
      if (sp_swallow == SW_DROP) begin
         sp_swallow = SW_NONE;
         return;
      end
      if (sp_swallow == SW_TEXT_LF) begin
         sp_swallow = SW_NONE;
         keep_byte(ch);
         if (sp_len >= split_point(limit_reg)) close_expr(MODE_TEXT);
         return;
      end
      case (sp_mode)
         MODE_SQUOTE, MODE_DQUOTE: begin
            if (sp_len >= split_point(limit_reg)) begin
               overflow_expr();
            end else begin
               if ((sp_mode == MODE_SQUOTE && ch == CHAR_SQUOTE) ||
                   (sp_mode == MODE_DQUOTE && ch == CHAR_DQUOTE)) sp_mode = MODE_CODE;
               keep_byte(ch);
            end
         end
         MODE_BLOCK: begin
            if (ch == CHAR_LF) sp_lines = next_line(sp_lines);
            if (ch == CHAR_STAR && nx == CHAR_SLASH) begin
               sp_swallow = SW_DROP;
               sp_mode    = MODE_CODE;
            end
         end
         MODE_LINE: begin
            if (eol) begin
               if (ch == CHAR_CR) sp_swallow = SW_DROP;
               sp_lines = next_line(sp_lines);
               sp_mode  = MODE_CODE;
               if (sp_semi) sp_semi = 1'b0;
               else if (sp_len != 0) close_expr(MODE_CODE);
            end
         end
         MODE_CODE: begin
            if (ch == CHAR_DOLLAR && nx == CHAR_GT) begin
               sp_swallow = SW_DROP;
               close_expr(MODE_CODE);
               sp_mode = MODE_TEXT;
            end else if (ch == CHAR_SLASH && nx == CHAR_STAR) begin
               sp_mode = MODE_BLOCK;
            end else if (ch == CHAR_SLASH && nx == CHAR_SLASH) begin
               sp_mode = MODE_LINE;
            end else if (eol) begin
               if (ch == CHAR_CR) sp_swallow = SW_DROP;
               sp_lines = next_line(sp_lines);
               if (sp_semi) sp_semi = 1'b0;
               else if (sp_len != 0) close_expr(MODE_CODE);
            end else if (ch == CHAR_SEMI) begin
               sp_semi = 1'b1;
            end else if (ch == CHAR_SPACE || ch == CHAR_TAB) begin
               if (sp_len > 0 && !sp_space) begin
                  if (sp_len >= split_point(limit_reg)) overflow_expr();
                  else keep_byte(CHAR_SPACE);
               end
            end else begin
               if (sp_semi && sp_len > 0) close_expr(MODE_CODE);
               if (sp_len == 0) sp_start = next_line(sp_lines);
               if (sp_len >= split_point(limit_reg)) begin
                  overflow_expr();
               end else begin
                  keep_byte(ch);
                  if (ch == CHAR_SQUOTE) sp_mode = MODE_SQUOTE;
                  else if (ch == CHAR_DQUOTE) sp_mode = MODE_DQUOTE;
               end
            end
         end
         default: begin
            sp_mode = MODE_TEXT;
            if (eol) sp_lines = next_line(sp_lines);
            if (eol && ch == CHAR_CR) begin
               keep_byte(ch);
               sp_swallow = SW_TEXT_LF;
            end else if (ch == CHAR_LT && nx == CHAR_DOLLAR) begin
               sp_swallow = SW_DROP;
               sp_mode    = MODE_CODE;
               if (sp_len != 0) close_expr(MODE_TEXT);
            end else begin
               keep_byte(ch);
               if (sp_len >= split_point(limit_reg)) close_expr(MODE_TEXT);
            end
         end
      endcase
   endtask

   task automatic split_byte(input logic [7:0] b, input logic last);
      sp_count = 0;
      sp_ended = 1'b0;
      if (sp_held_ok) judge_byte(sp_held, b);
      sp_held    = b;
      sp_held_ok = 1'b1;
      if (last) begin
         judge_byte(b, 8'd0);
         if (sp_len > 0 || !sp_ended) close_expr(sp_mode);
         clear_split();
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
   endtask

   task automatic add_letters(input int n);
      for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom_range(97, 122)));
   endtask

   // Template-like fragments with a share of broken pieces and raw noise.
   task automatic add_fragment();
      int pick;
      logic [7:0] q;
      pick = $urandom_range(0, 19);
      case (pick)
         0, 1, 2: add_letters($urandom_range(1, 8));
         3, 4: add_text("<$");
         5, 6: add_text("$>");
         7: begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
               file_buf.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
         end
         8: add_text(";");
         9: begin
            q = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
            file_buf.push_back(q);
            add_letters($urandom_range(0, 5));
            if ($urandom_range(0, 3) == 0) add_text(" ;");
            if ($urandom_range(0, 4) != 0) file_buf.push_back(q);
         end
         10: begin
            add_text("/*");
            add_letters($urandom_range(0, 4));
            if ($urandom_range(0, 1) == 0) add_text("\015\n");
            if ($urandom_range(0, 4) != 0) add_text("*/");
         end
         11: begin
            add_text("//");
            add_letters($urandom_range(0, 4));
            if ($urandom_range(0, 1) == 0) add_text("\015\n");
            else add_text("\n");
         end
         12: add_text("\015\n");
         13: add_text("\n");
         14: add_text("\015");
         15: file_buf.push_back(8'($urandom_range(0, 255)));
         16: begin
            case ($urandom_range(0, 5))
               0: file_buf.push_back(CHAR_LT);
               1: file_buf.push_back(CHAR_DOLLAR);
               2: file_buf.push_back(CHAR_GT);
               3: file_buf.push_back(CHAR_STAR);
               4: file_buf.push_back(CHAR_SLASH);
               default: file_buf.push_back(CHAR_SEMI);
            endcase
         end
         17, 18: begin
            add_letters($urandom_range(1, 4));
            add_text(" ");
         end
         default: add_letters($urandom_range(10, 30));
      endcase
   endtask

   task automatic send_file();
      src_byte_type sb;
      for (int i = 0; i < file_buf.size(); i++) begin
         sb.value = file_buf[i];
         sb.last  = (i == file_buf.size() - 1);
         source_bytes.push_back(sb);
         unsent_bytes++;
      end
   endtask

   task automatic drain();
      while (unsent_bytes != 0 || split_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limit_reg = v;
   endtask

   task automatic run_phase(input logic [15:0] lim, input int send_pct, input int recv_pct,
                            input int n_items, input bit squeeze);
      int queued;
      int flen;
      write_limit(lim);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      queued = 0;
      while (queued < n_items) begin
         flen = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 24);
         file_buf.delete();
         while (file_buf.size() < flen) add_fragment();
         while (file_buf.size() > flen) void'(file_buf.pop_back());
         send_file();
         queued += flen;
      end
      if (squeeze) want_squeeze = 1'b1;
      drain();
   endtask

   always begin : feed_side
      bit took;
      src_byte_type nb;
      @(posedge clock);
      took = !reset && req_valid && req_ready;
      if (took) begin
         split_byte(req_byte_value, req_is_last);
         unsent_bytes--;
      end
      @(negedge clock);
      if (took || !req_valid) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!reset && source_bytes.size() != 0) begin
            if ($urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(0, 18);
               req_valid <= 1'b0;
            end else begin
               nb = source_bytes.pop_front();
               req_valid      <= 1'b1;
               req_byte_value <= nb.value;
               req_is_last    <= nb.last;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // A long hold-off lets the result queue fill so that the input stalls.
   always @(negedge clock) begin
      if (want_squeeze && !squeeze_done) begin
         squeeze_done = 1'b1;
         hold_cycles  = 80;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (!reset && $urandom_range(0, 99) < recv_idle_pct) begin
         hold_cycles = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset;
      end
   end

   always @(posedge clock) begin : check_side
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (split_results.size() == 0) begin
            $error("unexpected result beat: char_value %0d, expr_end %0b",
                   rsp_char_value, rsp_expr_end);
            failures++;
         end else begin
            want = split_results.pop_front();
            check_field("char_value", want.char_value, rsp_char_value);
            check_field("char_valid", want.char_valid, rsp_char_valid);
            check_field("expr_end", want.expr_end, rsp_expr_end);
            check_field("expr_kind", want.expr_kind, rsp_expr_kind);
            check_field("expr_length", want.expr_length, rsp_expr_length);
            check_field("expr_line", want.expr_line, rsp_expr_line);
            check_field("error", want.error, rsp_error);
         end
      end
   end

   initial begin
      limit_reg = EXPR_LIMIT_RESET;
      clear_split();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      file_buf.delete();
      add_text("\015\n<$x \t;'a'/*\015\n*/y//c\n$>");
      file_buf.push_back(8'h00);
      file_buf.push_back(8'hFF);
      send_file();
      drain();
      run_phase(16'd16, 10, 10, 60, 1'b0);
      run_phase(16'hFFFF, 10, 10, 60, 1'b1);
      run_phase(16'd17, 25, 5, 50, 1'b0);
      run_phase(16'($urandom_range(18, 64)), 5, 30, 50, 1'b0);
      run_phase(16'($urandom_range(16, 65535)), 0, 0, 50, 1'b0);
      repeat (12) @(negedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("tb: failure");
      $finish;
   end

endmodule
